### hdl/tdcsh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdcsh_pkg
// shared types and constants of the tdc subevent histogrammer
// ----------------------------------------------------------------------------
package tdcsh_pkg;

  // default sizes
  localparam int unsigned CHANNELS_DEF   = 64;
  localparam int unsigned BIN_BITS_DEF   = 10;
  localparam int unsigned COUNT_BITS_DEF = 32;

  // function codes of an input item
  localparam logic [1:0] FUNC_WORD   = 2'd0;
  localparam logic [1:0] FUNC_RD_BIN = 2'd1;
  localparam logic [1:0] FUNC_RD_TOT = 2'd2;

  // result status codes
  localparam logic [1:0] ST_IGNORED  = 2'd0;
  localparam logic [1:0] ST_COUNTED  = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;
  localparam logic [1:0] ST_READ     = 2'd3;

  // configuration register indexes
  localparam logic CFG_SUBEVENT_ID = 1'b0;
  localparam logic CFG_MODULE      = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] word;
    logic        first_word;
    logic [15:0] subevent_size;
    logic [31:0] subevent_id;
    logic [5:0]  read_channel;
    logic [9:0]  read_bin;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_data;
  } out_item_t;

  // decode of one item, from the parser to the counter stage
  typedef struct packed {
    logic [1:0]  status;
    logic        inc;      // increment bin and total
    logic        use_bin;  // return bin content
    logic        use_tot;  // return channel total
    logic [5:0]  chan;
    logic [15:0] bin;      // bin index, zero extended
  } parse_t;

endpackage

### hdl/tdcsh_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdcsh_if
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface tdcsh_in_if;
  import tdcsh_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tdcsh_out_if;
  import tdcsh_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hdl/tdcsh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdcsh_ram
// simple dual-port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tdcsh_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  // read returns the old content on a same-address write
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/tdcsh_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdcsh_parser
// subevent framing state and decode of one input item
// ----------------------------------------------------------------------------
module tdcsh_parser #(
  parameter int unsigned CHANNELS = 64,
  parameter int unsigned BIN_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  tdcsh_pkg::in_item_t item_i,
  input  logic [31:0]        sel_id_i,
  input  logic [3:0]         sel_module_i,
  output tdcsh_pkg::parse_t  parse_o
);
  import tdcsh_pkg::*;

  localparam int unsigned NBINS = 1 << BIN_BITS;

  logic [15:0] pos_q, pos_d;
  logic        acc_q, acc_d;
  logic [15:0] pos;
  logic        acc_now;
  logic [17:0] hdr_len;
  logic [3:0]  wmod;
  logic [5:0]  wchan;
  logic [15:0] wbin;

  always_comb begin
    parse_o = '0;
    pos_d   = pos_q;
    acc_d   = acc_q;
    pos     = item_i.first_word ? 16'd0 : pos_q;
    acc_now = acc_q;
    wmod    = item_i.word[31:28];
    wchan   = item_i.word[27:22];
    wbin    = item_i.word[15:0] >> (16 - BIN_BITS);
    hdr_len = {item_i.subevent_size - 16'd1, 2'b00};
    unique case (item_i.func)
      FUNC_WORD: begin
        if (item_i.first_word) begin
          acc_now = (item_i.subevent_id == sel_id_i) && (item_i.subevent_size >= 16'd4);
          if (!acc_now) begin
            parse_o.status = ST_REJECTED;
          end
        end
        if (!item_i.first_word && acc_now && (pos < item_i.subevent_size)) begin
          if (pos == 16'd1) begin
            // length word of the header
            if ({2'b00, item_i.word[15:0]} != hdr_len) begin
              acc_now        = 1'b0;
              parse_o.status = ST_REJECTED;
            end
          end else if (pos >= 16'd4) begin
            if ((wmod == sel_module_i) && ({1'b0, wchan} < 7'(CHANNELS))) begin
              parse_o.inc    = 1'b1;
              parse_o.status = ST_COUNTED;
              parse_o.chan   = wchan;
              parse_o.bin    = wbin;
            end
          end
        end
        acc_d = acc_now;
        pos_d = (pos != 16'hffff) ? pos + 16'd1 : pos;
      end
      FUNC_RD_BIN: begin
        parse_o.status  = ST_READ;
        parse_o.chan    = item_i.read_channel;
        parse_o.bin     = {6'd0, item_i.read_bin};
        parse_o.use_bin = ({1'b0, item_i.read_channel} < 7'(CHANNELS))
                          && ({7'd0, item_i.read_bin} < 17'(NBINS));
      end
      FUNC_RD_TOT: begin
        parse_o.status  = ST_READ;
        parse_o.chan    = item_i.read_channel;
        parse_o.use_tot = {1'b0, item_i.read_channel} < 7'(CHANNELS);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      acc_q <= 1'b0;
    end else if (accept_i) begin
      pos_q <= pos_d;
      acc_q <= acc_d;
    end
  end

endmodule

### hdl/tdc_subevent_histogrammer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_subevent_histogrammer
// per-channel tdc histograms built from subevent data words
// ----------------------------------------------------------------------------
// Takes one item per cycle unless the output stalls and returns one result per
// item via the counter and output registers. Subevent words of the selected
// id and module increment a bin of CHANNELS x 2^BIN_BITS and a per-channel
// total, both saturating at COUNT_BITS; reads return a bin or a total clipped
// to 32 bits. Counters live in two memories with a registered read; the
// read-modify-write of the bin memory sets the rate, and a one-entry bypass of
// the last write keeps back-to-back hits on one bin at one item per cycle.
// After reset a clearing pass walks all CHANNELS * 2^BIN_BITS bin addresses
// (65536 with the defaults) and zeroes both memories; no input is taken until
// it ends, while configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module tdc_subevent_histogrammer #(
  parameter int unsigned CHANNELS   = tdcsh_pkg::CHANNELS_DEF,
  parameter int unsigned BIN_BITS   = tdcsh_pkg::BIN_BITS_DEF,
  parameter int unsigned COUNT_BITS = tdcsh_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  tdcsh_in_if.sink    in_i,
  tdcsh_out_if.source out_o
);
  import tdcsh_pkg::*;

  localparam int unsigned DEPTH  = CHANNELS * (1 << BIN_BITS);
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned TOT_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef logic [COUNT_BITS-1:0] count_t;

  function automatic logic [31:0] sat32(count_t v);
    logic [63:0] ext;
    ext = 64'(v);
    return (ext > 64'h0000_0000_ffff_ffff) ? 32'hffff_ffff : ext[31:0];
  endfunction

  // configuration registers
  logic [31:0] sel_id_q;
  logic [3:0]  sel_module_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_id_q     <= 32'd1;
      sel_module_q <= 4'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SUBEVENT_ID: sel_id_q     <= cfg_data_i;
        CFG_MODULE:      sel_module_q <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  // clearing pass after reset
  logic          clearing_q;
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // handshake and stage control
  logic s1_valid_q, s1_adv, accept;
  logic out_valid_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !clearing_q && (!s1_valid_q || s1_adv);
  assign accept     = in_i.valid && in_i.ready;

  // decode stage
  parse_t        parse;
  logic [AW-1:0] bin_addr;
  logic [TOT_AW-1:0] tot_addr;

  tdcsh_parser #(
    .CHANNELS (CHANNELS),
    .BIN_BITS (BIN_BITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .item_i       (in_i.payload),
    .sel_id_i     (sel_id_q),
    .sel_module_i (sel_module_q),
    .parse_o      (parse)
  );

  assign bin_addr = AW'({parse.chan, parse.bin[BIN_BITS-1:0]});
  assign tot_addr = parse.chan[TOT_AW-1:0];

  // counter stage registers
  logic [1:0]        s1_status_q;
  logic              s1_inc_q, s1_use_bin_q, s1_use_tot_q;
  logic [AW-1:0]     s1_bin_addr_q;
  logic [TOT_AW-1:0] s1_tot_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q   <= parse.status;
      s1_inc_q      <= parse.inc;
      s1_use_bin_q  <= parse.use_bin;
      s1_use_tot_q  <= parse.use_tot;
      s1_bin_addr_q <= bin_addr;
      s1_tot_addr_q <= tot_addr;
    end
  end

  // counter memories
  count_t            bin_rdata, tot_rdata;
  logic              bin_we, tot_we;
  logic [AW-1:0]     bin_waddr;
  logic [TOT_AW-1:0] tot_waddr;
  count_t            bin_wdata, tot_wdata;

  tdcsh_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (COUNT_BITS)
  ) u_bin_ram (
    .clk_i     (clk_i),
    .rd_en_i   (accept && (parse.inc || parse.use_bin)),
    .rd_addr_i (bin_addr),
    .rd_data_o (bin_rdata),
    .wr_en_i   (bin_we),
    .wr_addr_i (bin_waddr),
    .wr_data_i (bin_wdata)
  );

  tdcsh_ram #(
    .DEPTH (CHANNELS),
    .AW    (TOT_AW),
    .DW    (COUNT_BITS)
  ) u_tot_ram (
    .clk_i     (clk_i),
    .rd_en_i   (accept && (parse.inc || parse.use_tot)),
    .rd_addr_i (tot_addr),
    .rd_data_o (tot_rdata),
    .wr_en_i   (tot_we),
    .wr_addr_i (tot_waddr),
    .wr_data_i (tot_wdata)
  );

  // bypass of the last counter write, covers a read issued on the same edge
  logic              fw_bin_vld_q, fw_tot_vld_q;
  logic [AW-1:0]     fw_bin_addr_q;
  logic [TOT_AW-1:0] fw_tot_addr_q;
  count_t            fw_bin_data_q, fw_tot_data_q;
  count_t            bin_cur, tot_cur, bin_inc, tot_inc;
  logic              cnt_wr;

  assign bin_cur = (fw_bin_vld_q && (fw_bin_addr_q == s1_bin_addr_q)) ? fw_bin_data_q
                                                                      : bin_rdata;
  assign tot_cur = (fw_tot_vld_q && (fw_tot_addr_q == s1_tot_addr_q)) ? fw_tot_data_q
                                                                      : tot_rdata;
  // saturating increments
  assign bin_inc = (bin_cur == '1) ? bin_cur : bin_cur + COUNT_BITS'(1);
  assign tot_inc = (tot_cur == '1) ? tot_cur : tot_cur + COUNT_BITS'(1);
  assign cnt_wr  = s1_adv && s1_inc_q;

  // write port: clearing pass first, then counter updates
  always_comb begin
    if (clearing_q) begin
      bin_we    = 1'b1;
      bin_waddr = clr_cnt_q;
      bin_wdata = '0;
      tot_we    = clr_cnt_q < AW'(CHANNELS);
      tot_waddr = clr_cnt_q[TOT_AW-1:0];
      tot_wdata = '0;
    end else begin
      bin_we    = cnt_wr;
      bin_waddr = s1_bin_addr_q;
      bin_wdata = bin_inc;
      tot_we    = cnt_wr;
      tot_waddr = s1_tot_addr_q;
      tot_wdata = tot_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_bin_vld_q <= 1'b0;
      fw_tot_vld_q <= 1'b0;
    end else if (cnt_wr) begin
      fw_bin_vld_q <= 1'b1;
      fw_tot_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_wr) begin
      fw_bin_addr_q <= s1_bin_addr_q;
      fw_bin_data_q <= bin_inc;
      fw_tot_addr_q <= s1_tot_addr_q;
      fw_tot_data_q <= tot_inc;
    end
  end

  // output register
  logic [1:0]  out_status_q;
  logic [31:0] out_data_q;
  logic [31:0] rd_value;

  always_comb begin
    if (s1_use_bin_q) begin
      rd_value = sat32(bin_cur);
    end else if (s1_use_tot_q) begin
      rd_value = sat32(tot_cur);
    end else begin
      rd_value = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_status_q <= s1_status_q;
      out_data_q   <= rd_value;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.payload.status    = out_status_q;
  assign out_o.payload.read_data = out_data_q;

`ifndef SYNTH
  // every transfer lands in the counter stage
  a_accept_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> s1_valid_q)
    else $error("accepted item missing from counter stage");

  // counters never wrap to zero
  a_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_inc_q) |-> (bin_inc != '0) && (tot_inc != '0))
    else $error("counter wrapped");

  // pipeline stays empty while the memories are cleared
  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !s1_valid_q && !out_valid_q)
    else $error("item in flight during clearing pass");
`endif

endmodule

### bench/tdc_subevent_histogrammer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_subevent_histogrammer_tb
// self-checking bench for the per-channel tdc subevent histogrammer
// ----------------------------------------------------------------------------
// Drives subevent words and read accesses over the valid/ready input channel
// and checks every result, in order, against a cycle-free model of the
// parser, the bin store and the channel totals kept inside the bench.
// Directed tests cover the reset contents, stray words, header words, words
// past the size, every rejection path and both register extremes; random
// traffic then runs mostly well-formed subevents under several register
// settings, with random gaps on the sender and random stalls on the receiver
// except in the final part.
// ----------------------------------------------------------------------------
module tdc_subevent_histogrammer_tb;
  import tdcsh_pkg::*;

  localparam int CHANNELS = CHANNELS_DEF;
  localparam int BIN_BITS = BIN_BITS_DEF;
  localparam int BINS     = 1 << BIN_BITS;

  // func code that the block leaves unused
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // ------------------------------------------------------------------------
  // clock, reset, block under test
  // ------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;

  tdcsh_in_if  in_ch ();
  tdcsh_out_if out_ch ();

  tdc_subevent_histogrammer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_i        (in_ch.sink),
    .out_o       (out_ch.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------------
  // histogram model: registers, parser state, bins and totals
  // ------------------------------------------------------------------------
  logic [31:0] sel_id;
  logic [3:0]  sel_module;
  logic [15:0] word_pos;
  logic        sub_taken;
  logic [31:0] bin_count [CHANNELS * BINS];
  logic [31:0] chan_total [CHANNELS];

  // results still owed by the block, oldest first
  out_item_t   result_q[$];

  // run bookkeeping
  int          errors;
  int          n_items;
  int          n_counted;
  int          n_rejected;
  int          n_reads;
  int          n_settings;

  // traffic shaping
  bit          idle_on;
  int          gap_pct;
  logic [31:0] last_word;

  // saturating increment at the 32-bit counter width
  function automatic logic [31:0] bump(input logic [31:0] c);
    return (c == 32'hffff_ffff) ? c : c + 32'd1;
  endfunction

  // next result of the block for one accepted item, updating the model state
  function automatic out_item_t predict_result(input in_item_t it);
    out_item_t   r;
    logic [31:0] want_len;
    int          ch;
    int          b;
    r = '0;
    case (it.func)
      FUNC_RD_BIN: begin
        r.status = ST_READ;
        if (it.read_channel < CHANNELS && it.read_bin < BINS)
          r.read_data = bin_count[int'(it.read_channel) * BINS + int'(it.read_bin)];
      end
      FUNC_RD_TOT: begin
        r.status = ST_READ;
        if (it.read_channel < CHANNELS)
          r.read_data = chan_total[it.read_channel];
      end
      FUNC_WORD: begin
        // a first word restarts the position and decides on the subevent
        if (it.first_word) begin
          word_pos  = '0;
          sub_taken = (it.subevent_id == sel_id) && (it.subevent_size >= 16'd4);
          if (!sub_taken) r.status = ST_REJECTED;
        end
        // the current size input rules, even if it changed mid-subevent
        if (!it.first_word && sub_taken && word_pos < it.subevent_size) begin
          if (word_pos == 16'd1) begin
            // length word, compared at full width against (size-1)*4
            want_len = ({16'd0, it.subevent_size} - 32'd1) << 2;
            if ({16'd0, it.word[15:0]} != want_len) begin
              sub_taken = 1'b0;
              r.status  = ST_REJECTED;
            end
          end else if (word_pos >= 16'd4) begin
            ch = int'(it.word[27:22]);
            b  = int'(it.word[15:0] >> (16 - BIN_BITS));
            if (it.word[31:28] == sel_module && ch < CHANNELS) begin
              bin_count[ch * BINS + b] = bump(bin_count[ch * BINS + b]);
              chan_total[ch]           = bump(chan_total[ch]);
              r.status                 = ST_COUNTED;
            end
          end
        end
        // position sticks at all ones
        if (word_pos != 16'hffff) word_pos = word_pos + 16'd1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // item builders
  // ------------------------------------------------------------------------
  function automatic in_item_t random_item();
    in_item_t it;
    it.func          = 2'($urandom_range(0, 3));
    it.word          = $urandom;
    it.first_word    = 1'($urandom_range(0, 1));
    it.subevent_size = 16'($urandom);
    it.subevent_id   = $urandom;
    it.read_channel  = 6'($urandom);
    it.read_bin      = 10'($urandom);
    return it;
  endfunction

  function automatic in_item_t word_item(input logic first, input logic [15:0] size,
                                         input logic [31:0] id, input logic [31:0] w);
    in_item_t it;
    it               = random_item();
    it.func          = FUNC_WORD;
    it.first_word    = first;
    it.subevent_size = size;
    it.subevent_id   = id;
    it.word          = w;
    return it;
  endfunction

  function automatic in_item_t read_item(input logic [1:0] f, input logic [5:0] ch,
                                         input logic [9:0] b);
    in_item_t it;
    it              = random_item();
    it.func         = f;
    it.read_channel = ch;
    it.read_bin     = b;
    return it;
  endfunction

  // tdc word: module, channel, unused bits random, 16-bit value
  function automatic logic [31:0] tdc_word(input logic [3:0] m, input logic [5:0] ch,
                                           input logic [15:0] val);
    return {m, ch, 6'($urandom), val};
  endfunction

  // data word of a subevent, mostly for the selected module, with crowding
  // on a few channels and repeats of one bin to stress the bypass
  function automatic logic [31:0] data_word();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 6) != 0) w[31:28] = sel_module;
    if ($urandom_range(0, 3) == 0) w[27:22] = 6'($urandom_range(0, 3));
    if ($urandom_range(0, 4) == 0) w = last_word;
    last_word = w;
    return w;
  endfunction

  // ------------------------------------------------------------------------
  // sender: one item per call, optional gap before it
  // ------------------------------------------------------------------------
  task automatic send_item(input in_item_t it);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 17);
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    // transfer happens at the first rising edge with ready high
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    result_q.push_back(predict_result(it));
    n_items++;
    case (result_q[$].status)
      ST_COUNTED:  n_counted++;
      ST_REJECTED: n_rejected++;
      ST_READ:     n_reads++;
      default: ;
    endcase
  endtask

  // read back a recently hit bin or total, or an arbitrary one; some items carry the unused func
  task automatic send_read();
    in_item_t it;
    it = random_item();
    case ($urandom_range(0, 7))
      0:       it.func = FUNC_UNUSED;
      1, 2, 3: it.func = FUNC_RD_TOT;
      default: it.func = FUNC_RD_BIN;
    endcase
    if ($urandom_range(0, 2) != 0) begin
      it.read_channel = last_word[27:22];
      it.read_bin     = 10'(last_word[15:0] >> (16 - BIN_BITS));
    end
    send_item(it);
  endtask

  // one subevent of len words: size0 on the first word, size1 on the rest;
  // a correct length word unless bad_len, reads mixed in when mix is set
  task automatic run_subevent(input logic [31:0] id, input logic [15:0] size0,
                              input logic [15:0] size1, input int len,
                              input bit bad_len, input bit mix);
    in_item_t    it;
    logic [15:0] sz;
    for (int p = 0; p < len; p++) begin
      sz = (p == 0) ? size0 : size1;
      it = word_item(p == 0, sz, id, $urandom);
      if (p == 1) begin
        it.word[15:0] = 16'((sz - 16'd1) << 2);
        if (bad_len) it.word[15:0] = it.word[15:0] ^ 16'(1 << $urandom_range(0, 15));
      end else if (p >= 4) begin
        it.word = data_word();
      end
      if (mix && $urandom_range(0, 7) == 0) send_read();
      send_item(it);
    end
  endtask

  // drop valid and wait for every owed result, plus the pipeline depth
  task automatic settle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // both registers, on back-to-back cycles, only with the block drained
  task automatic set_config(input logic [31:0] id, input logic [3:0] m);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SUBEVENT_ID;
    cfg_data  <= id;
    @(negedge clk_i);
    cfg_index <= CFG_MODULE;
    cfg_data  <= {28'd0, m};
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    sel_id     = id;
    sel_module = m;
    n_settings++;
  endtask

  // ------------------------------------------------------------------------
  // result checker
  // ------------------------------------------------------------------------
  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    out_item_t got;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = out_ch.payload;
      if (result_q.size() == 0) begin
        flag_error($sformatf("result with none owed: status %0d read_data %h",
                             got.status, got.read_data));
      end else begin
        want = result_q.pop_front();
        if (got.status !== want.status || got.read_data !== want.read_data)
          flag_error($sformatf("mismatch: status exp %0d got %0d, read_data exp %h got %h",
                               want.status, got.status, want.read_data, got.read_data));
      end
    end
  end

  // ------------------------------------------------------------------------
  // receiver: ready in random stretches, stall bursts only while idling
  // ------------------------------------------------------------------------
  initial begin : drive_ready
    int n;
    out_ch.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 17);
        out_ch.ready <= 1'b0;
      end else begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 30);
        out_ch.ready <= 1'b1;
      end
      repeat (n) @(negedge clk_i);
    end
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // words before any first word are ignored
  task automatic test_stray_words();
    send_item(word_item(1'b0, 16'd8, 32'd1, tdc_word(4'd0, 6'd0, 16'h0000)));
    send_item(word_item(1'b0, 16'd8, 32'd1, 32'd28));
  endtask

  // cleared store reads zero at both corners; unused func does nothing
  task automatic test_cleared_reads();
    send_item(read_item(FUNC_RD_BIN, 6'd0, 10'd0));
    send_item(read_item(FUNC_RD_BIN, 6'd63, 10'd1023));
    send_item(read_item(FUNC_RD_TOT, 6'd63, 10'd0));
    send_item(read_item(FUNC_UNUSED, 6'd5, 10'd5));
  endtask

  // accepted subevent with reset registers: header words, both value
  // extremes, a back-to-back hit, another module, a word past the size
  task automatic test_taken_subevent();
    send_item(word_item(1'b1, 16'd8, 32'd1, $urandom));
    send_item(word_item(1'b0, 16'd8, 32'd1, {16'($urandom), 16'd28}));
    send_item(word_item(1'b0, 16'd8, 32'd1, $urandom));
    send_item(word_item(1'b0, 16'd8, 32'd1, $urandom));
    send_item(word_item(1'b0, 16'd8, 32'd1, tdc_word(4'd0, 6'd0, 16'h0000)));
    send_item(word_item(1'b0, 16'd8, 32'd1, tdc_word(4'd0, 6'd63, 16'hffff)));
    send_item(word_item(1'b0, 16'd8, 32'd1, tdc_word(4'd0, 6'd63, 16'hffff)));
    send_item(word_item(1'b0, 16'd8, 32'd1, tdc_word(4'd7, 6'd1, 16'h1234)));
    send_item(word_item(1'b0, 16'd8, 32'd1, tdc_word(4'd0, 6'd1, 16'h1234)));
    send_item(read_item(FUNC_RD_BIN, 6'd63, 10'd1023));
    send_item(read_item(FUNC_RD_TOT, 6'd1, 10'd0));
  endtask

  // wrong id, size below four, size zero, bad length word, and a size whose
  // length cannot fit in 16 bits
  task automatic test_rejections();
    run_subevent(32'd2, 16'd8, 16'd8, 3, 1'b0, 1'b0);
    run_subevent(32'd1, 16'd3, 16'd3, 2, 1'b0, 1'b0);
    run_subevent(32'd1, 16'd0, 16'd0, 1, 1'b0, 1'b0);
    run_subevent(32'd1, 16'd8, 16'd8, 5, 1'b1, 1'b0);
    run_subevent(32'd1, 16'hffff, 16'hffff, 3, 1'b0, 1'b0);
  endtask

  // all-ones and all-zeros register values
  task automatic test_register_extremes();
    set_config(32'hffff_ffff, 4'hf);
    run_subevent(32'hffff_ffff, 16'd6, 16'd6, 6, 1'b0, 1'b0);
    send_read();
    set_config(32'd0, 4'd0);
    run_subevent(32'd0, 16'd5, 16'd5, 5, 1'b0, 1'b0);
    run_subevent(32'd1, 16'd5, 16'd5, 2, 1'b0, 1'b0);
  endtask

  // mostly well-formed subevents with random content, some broken ones,
  // some pure noise
  task automatic test_random_traffic(input int count);
    int          stop_at;
    int          kind;
    int          sz;
    int          len;
    logic [31:0] id;
    stop_at = n_items + count;
    while (n_items < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 8;
          default: gap_pct = 30;
        endcase
      end
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        sz  = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 300) : $urandom_range(4, 20);
        len = sz + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
        if ($urandom_range(0, 9) == 0) len = $urandom_range(1, sz);
        run_subevent(sel_id, 16'(sz), 16'(sz), len, 1'b0, 1'b1);
      end else if (kind < 88) begin
        sz = $urandom_range(4, 12);
        case ($urandom_range(0, 2))
          0: begin
            id = $urandom;
            if (id == sel_id) id = ~id;
            run_subevent(id, 16'(sz), 16'(sz), sz, 1'b0, 1'b1);
          end
          1: begin
            sz = $urandom_range(0, 3);
            run_subevent(sel_id, 16'(sz), 16'(sz), $urandom_range(1, 6), 1'b0, 1'b1);
          end
          default: run_subevent(sel_id, 16'(sz), 16'(sz), sz, 1'b1, 1'b1);
        endcase
      end else begin
        repeat ($urandom_range(1, 5)) send_item(random_item());
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------------
  initial begin : run_tests
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_SUBEVENT_ID;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    errors        = 0;
    n_items       = 0;
    n_counted     = 0;
    n_rejected    = 0;
    n_reads       = 0;
    n_settings    = 0;
    idle_on       = 1'b1;
    gap_pct       = 10;
    last_word     = '0;
    // model state after reset
    sel_id        = 32'd1;
    sel_module    = 4'd0;
    word_pos      = '0;
    sub_taken     = 1'b0;
    foreach (bin_count[i]) bin_count[i] = '0;
    foreach (chan_total[i]) chan_total[i] = '0;

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset register values are in force for the first tests
    test_stray_words();
    test_cleared_reads();
    test_taken_subevent();
    test_rejections();
    test_register_extremes();

    set_config($urandom, 4'($urandom));
    test_random_traffic(450);
    set_config(32'hffff_ffff, 4'hf);
    test_random_traffic(400);
    set_config(32'd0, 4'd0);
    test_random_traffic(400);

    // closing part at full rate, no gaps and no stalls
    idle_on = 1'b0;
    gap_pct = 0;
    set_config($urandom, 4'($urandom));
    test_random_traffic(450);

    settle();
    repeat (8) @(posedge clk_i);

    $display("covered %0d items: %0d words counted, %0d rejections, %0d reads",
             n_items, n_counted, n_rejected, n_reads);
    $display("register settings applied: %0d, mismatches: %0d", n_settings, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // clearing pass and all random traffic under worst stalls stay well
  // inside this bound
  initial begin : watchdog
    #10_000_000;
    $display("timeout with %0d results still owed", result_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
